### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pcsx_pkg.sv
`timescale 1ns / 1ps

package pcsx_pkg;

    localparam int ANGLE_BITS_DFLT    = 16;
    localparam int RADIUS_BITS_DFLT   = 16;
    localparam int CORDIC_STAGES_DFLT = 16;

    localparam int CMD_BITS    = 2;
    localparam int HEIGHT_BITS = 16;
    localparam int OUT_BITS    = 17;
    localparam int Q_FRAC      = 30;

    localparam longint CORDIC_GAIN_Q30 = 652032874;
    localparam longint HALF_Q30        = 536870912;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_POLAR = 2'd0,
        CMD_CYL   = 2'd1,
        CMD_SPH   = 2'd2
    } cmd_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            5'd31: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/polar_cylindrical_spherical_to_xyz_core.sv
`timescale 1ns / 1ps
//  channel | direction | beat contents
//  s_      | in        | command, radius, azimuth, polar_angle, height
//  m_      | out       | x_out, y_out, z_out
//
//  one beat per cycle sustained while m_ready stays high
//  one rotation stage per cordic iteration (two lanes, azimuth and polar)
//  plus angle fold, two multiply stages, two rounding stages
//  aresetn clears the stage valid bits only
//  a stalled stage holds; empty stages behind it keep filling

module polar_cylindrical_spherical_to_xyz_core #(
    parameter int ANGLE_BITS    = pcsx_pkg::ANGLE_BITS_DFLT,
    parameter int RADIUS_BITS   = pcsx_pkg::RADIUS_BITS_DFLT,
    parameter int CORDIC_STAGES = pcsx_pkg::CORDIC_STAGES_DFLT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [pcsx_pkg::CMD_BITS-1:0]          s_command,
    input  logic [RADIUS_BITS-1:0]                 s_radius,
    input  logic [ANGLE_BITS-1:0]                  s_azimuth,
    input  logic [ANGLE_BITS-1:0]                  s_polar_angle,
    input  logic signed [pcsx_pkg::HEIGHT_BITS-1:0] s_height,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pcsx_pkg::OUT_BITS-1:0]   m_x_out,
    output logic signed [pcsx_pkg::OUT_BITS-1:0]   m_y_out,
    output logic signed [pcsx_pkg::OUT_BITS-1:0]   m_z_out
);

    import pcsx_pkg::*;

    localparam int NC  = CORDIC_STAGES;
    localparam int NST = NC + 5;
    localparam int IM1 = NC + 1;
    localparam int IM2 = NC + 2;
    localparam int IM3 = NC + 3;
    localparam int IO  = NC + 4;

    localparam int TW   = 33;
    localparam int PRW  = RADIUS_BITS + 1 + TW;
    localparam int RW   = PRW - Q_FRAC;
    localparam int PSW  = RW + TW;
    localparam int SRW  = PSW - Q_FRAC;
    localparam int SW   = (SRW > OUT_BITS + 1) ? SRW : OUT_BITS + 1;

    localparam logic signed [TW-1:0] X_INIT = TW'(CORDIC_GAIN_Q30);
    localparam logic signed [TW-1:0] Z_LIM  = TW'(64'sd1073741824);
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sd1 <<< (OUT_BITS - 1));

    typedef struct packed {
        logic [CMD_BITS-1:0]          cmd;
        logic [RADIUS_BITS-1:0]       radius;
        logic signed [HEIGHT_BITS-1:0] height;
    } side_t;

    function automatic logic signed [RW-1:0] round_r(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] s;
        s = p + PRW'(HALF_Q30);
        return RW'(s >>> Q_FRAC);
    endfunction

    function automatic logic signed [SRW-1:0] round_s(input logic signed [PSW-1:0] p);
        logic signed [PSW-1:0] s;
        s = p + PSW'(HALF_Q30);
        return SRW'(s >>> Q_FRAC);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return OUT_BITS'(c);
    endfunction

    // stage valid bits and per-stage advance
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    assign en[NST-1] = !vld_reg[NST-1] || m_ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // sideband through the cordic and multiply stages
    side_t side_reg [IM3+1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= '{cmd: s_command, radius: s_radius, height: s_height};
        end
        for (int k = 1; k <= IM3; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // cordic lanes: 0 azimuth, 1 polar angle
    logic signed [TW-1:0] x_reg    [NC+1][2];
    logic signed [TW-1:0] y_reg    [NC+1][2];
    logic signed [TW-1:0] z_reg    [NC+1][2];
    logic                 flip_reg [NC+1][2];

    logic [31:0] ang_al [2];
    logic [31:0] ang_fold [2];
    logic        flip_next [2];

    assign ang_al[0] = 32'(s_azimuth) << (32 - ANGLE_BITS);
    assign ang_al[1] = 32'(s_polar_angle) << (32 - ANGLE_BITS);

    for (genvar l = 0; l < 2; l++) begin : g_fold
        // second and third quadrant folded by half a turn
        assign flip_next[l] = ang_al[l][31] ^ ang_al[l][30];
        assign ang_fold[l]  = {ang_al[l][31] ^ flip_next[l], ang_al[l][30:0]};

        always_ff @(posedge aclk) begin
            if (en[0]) begin
                x_reg[0][l]    <= X_INIT;
                y_reg[0][l]    <= '0;
                z_reg[0][l]    <= TW'($signed(ang_fold[l]));
                flip_reg[0][l] <= flip_next[l];
            end
        end
    end

    for (genvar j = 1; j <= NC; j++) begin : g_cordic
        localparam int SH = j - 1;
        localparam logic signed [TW-1:0] STEP = TW'(atan_turn(5'(SH)));

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [TW-1:0] x_next;
            logic signed [TW-1:0] y_next;
            logic signed [TW-1:0] z_next;

            always_comb begin
                if (!z_reg[j-1][l][TW-1]) begin
                    x_next = x_reg[j-1][l] - (y_reg[j-1][l] >>> SH);
                    y_next = y_reg[j-1][l] + (x_reg[j-1][l] >>> SH);
                    z_next = z_reg[j-1][l] - STEP;
                end else begin
                    x_next = x_reg[j-1][l] + (y_reg[j-1][l] >>> SH);
                    y_next = y_reg[j-1][l] - (x_reg[j-1][l] >>> SH);
                    z_next = z_reg[j-1][l] + STEP;
                end
            end

            always_ff @(posedge aclk) begin
                if (en[j]) begin
                    x_reg[j][l]    <= x_next;
                    y_reg[j][l]    <= y_next;
                    z_reg[j][l]    <= z_next;
                    flip_reg[j][l] <= flip_reg[j-1][l];
                end
            end
        end
    end

    // unfold and first multiply
    logic signed [TW-1:0] cos_next [2];
    logic signed [TW-1:0] sin_next [2];

    for (genvar l = 0; l < 2; l++) begin : g_unfold
        assign cos_next[l] = flip_reg[NC][l] ? -x_reg[NC][l] : x_reg[NC][l];
        assign sin_next[l] = flip_reg[NC][l] ? -y_reg[NC][l] : y_reg[NC][l];
    end

    logic signed [PRW-1:0] r_signed;
    assign r_signed = PRW'($signed({1'b0, side_reg[NC].radius}));

    logic signed [PRW-1:0] p_rc_reg, p_rs_reg, p_st_reg, p_ct_reg;
    logic signed [TW-1:0]  cp1_reg, sp1_reg;

    always_ff @(posedge aclk) begin
        if (en[IM1]) begin
            p_rc_reg <= r_signed * PRW'(cos_next[0]);
            p_rs_reg <= r_signed * PRW'(sin_next[0]);
            p_st_reg <= r_signed * PRW'(sin_next[1]);
            p_ct_reg <= r_signed * PRW'(cos_next[1]);
            cp1_reg  <= cos_next[0];
            sp1_reg  <= sin_next[0];
        end
    end

    // first rounding
    logic signed [RW-1:0] rcp_reg, rsp_reg, rs_reg, rct_reg;
    logic signed [TW-1:0] cp2_reg, sp2_reg;

    always_ff @(posedge aclk) begin
        if (en[IM2]) begin
            rcp_reg <= round_r(p_rc_reg);
            rsp_reg <= round_r(p_rs_reg);
            rs_reg  <= round_r(p_st_reg);
            rct_reg <= round_r(p_ct_reg);
            cp2_reg <= cp1_reg;
            sp2_reg <= sp1_reg;
        end
    end

    // second multiply, spherical only
    logic signed [PSW-1:0] p_xs_reg, p_ys_reg;
    logic signed [RW-1:0]  rcp3_reg, rsp3_reg, rct3_reg;

    always_ff @(posedge aclk) begin
        if (en[IM3]) begin
            p_xs_reg <= PSW'(rs_reg) * PSW'(cp2_reg);
            p_ys_reg <= PSW'(rs_reg) * PSW'(sp2_reg);
            rcp3_reg <= rcp_reg;
            rsp3_reg <= rsp_reg;
            rct3_reg <= rct_reg;
        end
    end

    // mode select, rounding and saturation
    logic signed [SW-1:0] xs_next, ys_next, zs_next;

    always_comb begin
        unique case (side_reg[IM3].cmd)
            CMD_POLAR: begin
                xs_next = SW'(rcp3_reg);
                ys_next = SW'(rsp3_reg);
                zs_next = '0;
            end
            CMD_CYL: begin
                xs_next = SW'(rcp3_reg);
                ys_next = SW'(rsp3_reg);
                zs_next = SW'(side_reg[IM3].height);
            end
            CMD_SPH: begin
                xs_next = SW'(round_s(p_xs_reg));
                ys_next = SW'(round_s(p_ys_reg));
                zs_next = SW'(rct3_reg);
            end
            default: begin
                xs_next = '0;
                ys_next = '0;
                zs_next = '0;
            end
        endcase
    end

    logic signed [OUT_BITS-1:0] x_out_reg, y_out_reg, z_out_reg;
    logic [CMD_BITS-1:0]        cmd_out_reg;

    always_ff @(posedge aclk) begin
        if (en[IO]) begin
            x_out_reg   <= sat(xs_next);
            y_out_reg   <= sat(ys_next);
            z_out_reg   <= sat(zs_next);
            cmd_out_reg <= side_reg[IM3].cmd;
        end
    end

    assign m_x_out = x_out_reg;
    assign m_y_out = y_out_reg;
    assign m_z_out = z_out_reg;

    `include "assert_macros.svh"

    `ASSERT_NOW(a_blocked_only_when_full, aclk, aresetn, !s_ready, &vld_reg, "input blocked with a free stage")
    `ASSERT_NOW(a_fold_az_range, aclk, aresetn, vld_reg[0], (z_reg[0][0] < Z_LIM) && (z_reg[0][0] >= -Z_LIM), "azimuth fold out of range")
    `ASSERT_NOW(a_fold_pol_range, aclk, aresetn, vld_reg[0], (z_reg[0][1] < Z_LIM) && (z_reg[0][1] >= -Z_LIM), "polar fold out of range")
    `ASSERT_NEXT(a_cordic_to_mult, aclk, aresetn, vld_reg[NC] && en[IM1], vld_reg[IM1], "beat lost leaving cordic")
    `ASSERT_NOW(a_polar_z_zero, aclk, aresetn, m_valid && (cmd_out_reg == CMD_POLAR), m_z_out == '0, "polar beat with non-zero z")

endmodule

### sim/pcsx_xyz_checker.sv
`timescale 1ns / 1ps

module pcsx_xyz_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [pcsx_pkg::CMD_BITS-1:0]           s_command,
    input  logic [pcsx_pkg::RADIUS_BITS_DFLT-1:0]   s_radius,
    input  logic [pcsx_pkg::ANGLE_BITS_DFLT-1:0]    s_azimuth,
    input  logic [pcsx_pkg::ANGLE_BITS_DFLT-1:0]    s_polar_angle,
    input  logic signed [pcsx_pkg::HEIGHT_BITS-1:0] s_height,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [pcsx_pkg::OUT_BITS-1:0]    m_x_out,
    input  logic signed [pcsx_pkg::OUT_BITS-1:0]    m_y_out,
    input  logic signed [pcsx_pkg::OUT_BITS-1:0]    m_z_out,
    output int                                      mismatches,
    output int                                      pending,
    output int                                      results_seen
);
    import pcsx_pkg::*;

    localparam int     ITERATIONS = CORDIC_STAGES_DFLT;
    localparam longint K_Q30      = 64'sd652032874;
    localparam longint ROUND_HALF = 64'sd536870912;
    localparam longint XYZ_MAX    = 64'sd65535;
    localparam longint XYZ_MIN    = -64'sd65536;

    // arctangent of 2^-i, fraction of a 32-bit turn
    localparam logic [31:0] ARCTAN_TURN [0:31] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
    } xyz_t;

    xyz_t xyz_due[$];
    xyz_t want;
    int   err_count  = 0;
    int   due_count  = 0;
    int   done_count = 0;

    assign mismatches   = err_count;
    assign pending      = due_count;
    assign results_seen = done_count;

    function automatic void sin_cos_q30(input logic [15:0] ang, output longint s,
                                        output longint c);
        logic [31:0] a;
        logic        mirror;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      step;
        int          i;
        a = {ang, 16'h0000};
        mirror = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (mirror) begin
            a = a - 32'h8000_0000;
        end
        z = longint'($signed(a));
        x = K_Q30;
        y = 0;
        for (i = 0; i < ITERATIONS; i++) begin
            step = longint'({32'h0, ARCTAN_TURN[i]});
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - step;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + step;
            end
            x = nx;
        end
        if (mirror) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint scale_q30(input longint p);
        return (p + ROUND_HALF) >>> 30;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] clamp_xyz(input longint v);
        longint t;
        t = (v > XYZ_MAX) ? XYZ_MAX : ((v < XYZ_MIN) ? XYZ_MIN : v);
        return t[OUT_BITS-1:0];
    endfunction

    function automatic xyz_t xyz_of(input logic [1:0] cmd, input logic [15:0] radius,
                                    input logic [15:0] azimuth, input logic [15:0] polar,
                                    input logic signed [15:0] height);
        longint r;
        longint h;
        longint sp;
        longint cp;
        longint st;
        longint ct;
        longint rs;
        longint x;
        longint y;
        longint z;
        xyz_t   res;
        r = longint'({48'h0, radius});
        h = height;
        x = 0;
        y = 0;
        z = 0;
        sin_cos_q30(azimuth, sp, cp);
        case (cmd)
            CMD_POLAR, CMD_CYL: begin
                x = scale_q30(r * cp);
                y = scale_q30(r * sp);
                z = (cmd == CMD_CYL) ? h : 0;
            end
            CMD_SPH: begin
                sin_cos_q30(polar, st, ct);
                rs = scale_q30(r * st);
                x  = scale_q30(rs * cp);
                y  = scale_q30(rs * sp);
                z  = scale_q30(r * ct);
            end
            default: begin
            end
        endcase
        res.x = clamp_xyz(x);
        res.y = clamp_xyz(y);
        res.z = clamp_xyz(z);
        return res;
    endfunction

    function automatic int field_bad(input string name, input logic signed [OUT_BITS-1:0] exp_v,
                                     input logic signed [OUT_BITS-1:0] got_v);
        if (exp_v === got_v) begin
            return 0;
        end
        $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
        return 1;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                done_count++;
                if (xyz_due.size() == 0) begin
                    $display("%0t unexpected result beat: expected none, got x=%0d y=%0d z=%0d",
                             $time, m_x_out, m_y_out, m_z_out);
                    err_count++;
                end else begin
                    want = xyz_due.pop_front();
                    err_count += field_bad("x_out", want.x, m_x_out);
                    err_count += field_bad("y_out", want.y, m_y_out);
                    err_count += field_bad("z_out", want.z, m_z_out);
                end
            end
            if (s_valid && s_ready) begin
                xyz_due.push_back(xyz_of(s_command, s_radius, s_azimuth, s_polar_angle,
                                         s_height));
            end
            due_count = xyz_due.size();
        end
    end

endmodule

### sim/tb_polar_cylindrical_spherical_to_xyz_core.sv
`timescale 1ns / 1ps

module tb_polar_cylindrical_spherical_to_xyz_core;
    import pcsx_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_BEATS   = 500;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = CORDIC_STAGES_DFLT + 5 + 24;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [CMD_BITS-1:0]          s_command;
    logic [RADIUS_BITS_DFLT-1:0]  s_radius;
    logic [ANGLE_BITS_DFLT-1:0]   s_azimuth;
    logic [ANGLE_BITS_DFLT-1:0]   s_polar_angle;
    logic signed [HEIGHT_BITS-1:0] s_height;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [OUT_BITS-1:0]   m_x_out;
    logic signed [OUT_BITS-1:0]   m_y_out;
    logic signed [OUT_BITS-1:0]   m_z_out;

    int mismatches;
    int pending;
    int results_seen;

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int rx_hold   = 0;
    int idle_cycles = 0;
    int beats_by_cmd[4];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    polar_cylindrical_spherical_to_xyz_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_radius      (s_radius),
        .s_azimuth     (s_azimuth),
        .s_polar_angle (s_polar_angle),
        .s_height      (s_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_out       (m_x_out),
        .m_y_out       (m_y_out),
        .m_z_out       (m_z_out)
    );

    pcsx_xyz_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_radius      (s_radius),
        .s_azimuth     (s_azimuth),
        .s_polar_angle (s_polar_angle),
        .s_height      (s_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_out       (m_x_out),
        .m_y_out       (m_y_out),
        .m_z_out       (m_z_out),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end else if (p < 88) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        if ($urandom_range(0, 3) == 0) begin
            a = {2'($urandom_range(0, 3)), 14'h0000};
            a = a + 16'($urandom_range(0, 4)) - 16'd2;
        end else begin
            a = 16'($urandom);
        end
        return a;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_beat(input logic [CMD_BITS-1:0] cmd, input logic [15:0] radius,
                             input logic [15:0] azimuth, input logic [15:0] polar,
                             input logic signed [15:0] height);
        int gap;
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_radius      <= radius;
        s_azimuth     <= azimuth;
        s_polar_angle <= polar;
        s_height      <= height;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        beats_by_cmd[cmd]++;
        @(negedge aclk);
        gap = tx_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random_beat();
        int                  p;
        logic [CMD_BITS-1:0] cmd;
        logic [15:0]         radius;
        p = $urandom_range(0, 19);
        cmd = (p < 6) ? CMD_POLAR : (p < 12) ? CMD_CYL : (p < 18) ? CMD_SPH : CMD_UNUSED;
        p = $urandom_range(0, 9);
        if (p == 0) begin
            radius = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (p == 1) begin
            radius = 16'($urandom_range(0, 255));
        end else begin
            radius = 16'($urandom);
        end
        send_beat(cmd, radius, pick_angle(), pick_angle(), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
    endtask

    // receiver: short random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_polar_cylindrical_spherical_to_xyz_core: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int n;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = CMD_POLAR;
        s_radius      = '0;
        s_azimuth     = '0;
        s_polar_angle = '0;
        s_height      = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, quadrant edges, every mode, ignored fields
        send_beat(CMD_POLAR,  16'd0,     16'd0,     16'hFFFF,  16'sh7FFF);
        send_beat(CMD_POLAR,  16'hFFFF,  16'd0,     16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'hFFFF,  16'd16384, 16'd12345, -16'sd32768);
        send_beat(CMD_POLAR,  16'hFFFF,  16'd32768, 16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'hFFFF,  16'd49152, 16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'hFFFF,  16'hFFFF,  16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'd40000, 16'd16383, 16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'd40000, 16'd16385, 16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'd40000, 16'd32767, 16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'd40000, 16'd49151, 16'd0,     16'sh0000);
        send_beat(CMD_POLAR,  16'd40000, 16'd49153, 16'd0,     16'sh0000);
        send_beat(CMD_CYL,    16'd1234,  16'd8192,  16'hFFFF,  16'sh7FFF);
        send_beat(CMD_CYL,    16'hFFFF,  16'd24576, 16'd0,     -16'sd32768);
        send_beat(CMD_CYL,    16'd0,     16'hFFFF,  16'd0,     16'sh0000);
        send_beat(CMD_CYL,    16'd1,     16'd40960, 16'd0,     -16'sd1);
        send_beat(CMD_SPH,    16'hFFFF,  16'd0,     16'd0,     16'sh7FFF);
        send_beat(CMD_SPH,    16'hFFFF,  16'd0,     16'd32768, -16'sd32768);
        send_beat(CMD_SPH,    16'hFFFF,  16'd0,     16'd16384, 16'sh0000);
        send_beat(CMD_SPH,    16'hFFFF,  16'd16384, 16'd49152, 16'sh0000);
        send_beat(CMD_SPH,    16'hFFFF,  16'hFFFF,  16'hFFFF,  16'sh5555);
        send_beat(CMD_SPH,    16'd0,     16'd12345, 16'd54321, 16'sh0000);
        send_beat(CMD_SPH,    16'd30000, 16'd8192,  16'd8192,  16'sh0000);
        send_beat(CMD_UNUSED, 16'hFFFF,  16'hFFFF,  16'hFFFF,  -16'sd1);
        send_beat(CMD_UNUSED, 16'd0,     16'd0,     16'd0,     16'sh0000);

        // sender waits for the pipe to empty
        s_valid <= 1'b0;
        wait_drained();

        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 150) begin
                // long receiver hold-off with the sender pushing back to back
                tx_gaps = 1'b0;
                rx_hold = HOLD_CYCLES;
            end else if (n == 220) begin
                tx_gaps = 1'b1;
            end else if (n == 260) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end else if (n == 340) begin
                tx_gaps   = 1'b1;
                rx_stalls = 1'b1;
            end else if (n == 400) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            send_random_beat();
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("beats: %0d polar, %0d cylindrical, %0d spherical, %0d unused command",
                 beats_by_cmd[CMD_POLAR], beats_by_cmd[CMD_CYL], beats_by_cmd[CMD_SPH],
                 beats_by_cmd[CMD_UNUSED]);
        $display("%0d results checked, %0d mismatches, long hold-off and drain pauses done",
                 results_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_polar_cylindrical_spherical_to_xyz_core: clean");
        end else begin
            $display("tb_polar_cylindrical_spherical_to_xyz_core: errors");
        end
        $finish;
    end

endmodule
